@@ src/indirect_block_run_classifier_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the indirect block run classifier
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INDIRECT_BLOCK_RUN_CLASSIFIER_UNIT_DEFINES_SVH
`define INDIRECT_BLOCK_RUN_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside of reset.
`define IBRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define IBRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define IBRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/ibrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ibrc_pkg
// Shared types and constants of the indirect block run classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ibrc_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned BLOCK_W         = 32;
  localparam int unsigned RUN_W           = 14;
  localparam int unsigned MAX_BLOCK_WORDS = 16384;

  typedef logic [RUN_W-1:0]   run_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BLOCK_W-1:0] block_t;

  // Saturation value of the run counter.
  localparam run_t RUN_MAX     = RUN_W'(MAX_BLOCK_WORDS - 1);
  localparam run_t THRESH_RST  = RUN_W'(8);

  // Classified word, passed from front to back.
  typedef struct packed {
    logic   first;         // first word of a block, no step test
    logic   step;          // word equals previous word plus one
    logic   last;          // final word of the block
    block_t block_number;
  } entry_t;

endpackage

`default_nettype wire

@@ src/ibrc_if.sv @@
// ----------------------------------------------------------------------------
// ibrc channel interfaces
// Valid/ready channels for words, results and the threshold register.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibrc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last_word;
  logic [31:0] block_number;

  modport source (output valid, output word, output last_word, output block_number,
                  input ready);
  modport sink   (input valid, input word, input last_word, input block_number,
                  output ready);
endinterface

interface ibrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_block;
  logic        is_indirect;

  modport source (output valid, output result_block, output is_indirect, input ready);
  modport sink   (input valid, input result_block, input is_indirect, output ready);
endinterface

interface ibrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [13:0] run_threshold;

  modport source (output valid, output run_threshold, input ready);
  modport sink   (input valid, input run_threshold, output ready);
endinterface

`default_nettype wire

@@ src/indirect_block_run_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// indirect_block_run_classifier_unit
// Classifies disk blocks as likely indirect pointer blocks from step runs.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                               transaction
//   -------  ---  ------------------------------------  -------------------
//   in_i     in   word, last_word, block_number         one block word
//   out_o    out  result_block, is_indirect             one block result
//   cfg_i    in   run_threshold                         threshold write
//
// Throughput is one word per cycle while the queue has room; a result is valid
// after its last word is accepted (queue write, then the back result register).
// The back's run counter update with its compare against the threshold sets
// the pace: one queue entry is retired per cycle unless a last word is stalled.
// Reset restores a threshold of 8 and starts a fresh block.
// A stalled result only holds back a last word; ordinary words keep draining.
//
`default_nettype none

module indirect_block_run_classifier_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ibrc_in_if.sink   in_i,
  ibrc_out_if.source out_o,
  ibrc_cfg_if.sink  cfg_i
);
  import ibrc_pkg::*;

  run_t   threshold_q;
  logic   push, q_full, q_valid, pop;
  entry_t push_entry, pop_entry;

  // Threshold register: writes always complete at once.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESH_RST;
    end else if (cfg_i.valid) begin
      threshold_q <= cfg_i.run_threshold;
    end
  end

  // Front: tag each word against the one before it.
  ibrc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .word_i         (in_i.word),
    .last_word_i    (in_i.last_word),
    .block_number_i (in_i.block_number),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // Decouple front from back so either can stall alone.
  ibrc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_entry)
  );

  // Back: count runs, decide and hold the result.
  ibrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .threshold_i    (threshold_q),
    .q_valid_i      (q_valid),
    .q_data_i       (pop_entry),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_block_o (out_o.result_block),
    .is_indirect_o  (out_o.is_indirect)
  );

endmodule

`default_nettype wire

@@ src/ibrc_front.sv @@
// ----------------------------------------------------------------------------
// ibrc_front
// Accepts words and tags each one as first word, step or break.
// ----------------------------------------------------------------------------
`default_nettype none

module ibrc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ibrc_pkg::word_t  word_i,
  input  wire logic            last_word_i,
  input  wire ibrc_pkg::block_t block_number_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output ibrc_pkg::entry_t     entry_o
);
  import ibrc_pkg::*;

  word_t prev_word_q;
  logic  at_start_q, at_start_d;
  word_t diff;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign diff       = word_i - prev_word_q;

  always_comb begin
    entry_o.first        = at_start_q;
    entry_o.step         = (diff == word_t'(1));
    entry_o.last         = last_word_i;
    entry_o.block_number = block_number_i;
  end

  // A last word opens a new block.
  assign at_start_d = push_o ? last_word_i : at_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
    end else begin
      at_start_q <= at_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      prev_word_q <= word_i;
    end
  end

endmodule

`default_nettype wire

@@ src/ibrc_queue.sv @@
// ----------------------------------------------------------------------------
// ibrc_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ibrc_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ibrc_pkg::entry_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output ibrc_pkg::entry_t      pop_data_o
);
  import ibrc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntFull);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/ibrc_back.sv @@
// ----------------------------------------------------------------------------
// ibrc_back
// Counts step runs, tracks rejection and registers the block result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indirect_block_run_classifier_unit_defines.svh"

module ibrc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ibrc_pkg::run_t   threshold_i,
  input  wire logic             q_valid_i,
  input  wire ibrc_pkg::entry_t q_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ibrc_pkg::block_t      result_block_o,
  output logic                  is_indirect_o
);
  import ibrc_pkg::*;

  run_t   cur_q, cur_d, lng_q, lng_d;
  logic   rej_q, rej_d;
  run_t   cur_n, lng_n, lng_fold;
  logic   rej_n, indirect;
  logic   out_valid_q, out_valid_d;
  block_t result_block_q;
  logic   is_indirect_q;
  logic   pop_last;

  // A last word needs a free result slot; other words always drain.
  assign pop_o    = q_valid_i && (!q_data_i.last || !out_valid_q || out_ready_i);
  assign pop_last = pop_o && q_data_i.last;

  always_comb begin
    cur_n = cur_q;
    lng_n = lng_q;
    rej_n = rej_q;
    if (q_data_i.first) begin
      cur_n = '0;
      lng_n = '0;
      rej_n = 1'b0;
    end else if (q_data_i.step) begin
      if (cur_q < RUN_MAX) begin
        cur_n = cur_q + run_t'(1);
      end
    end else begin
      if (cur_q != '0 && cur_q < threshold_i) begin
        rej_n = 1'b1;
      end else if (cur_q > lng_q) begin
        lng_n = cur_q;
      end
      cur_n = '0;
    end
    // Fold the trailing run in.
    lng_fold = (cur_n > lng_n) ? cur_n : lng_n;
    indirect = !rej_n && (lng_fold >= threshold_i);
  end

  always_comb begin
    cur_d = cur_q;
    lng_d = lng_q;
    rej_d = rej_q;
    if (pop_last) begin
      cur_d = '0;
      lng_d = '0;
      rej_d = 1'b0;
    end else if (pop_o) begin
      cur_d = cur_n;
      lng_d = lng_n;
      rej_d = rej_n;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      lng_q       <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      lng_q       <= lng_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      result_block_q <= q_data_i.block_number;
      is_indirect_q  <= indirect;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = result_block_q;
  assign is_indirect_o  = is_indirect_q;

  `IBRC_ASSERT_ALWAYS(a_run_sat, clk_i, cur_q <= RUN_MAX, "run counter above saturation")
  `IBRC_ASSERT(a_clear_after_last, clk_i, rst_ni, pop_last |=> (cur_q == '0 && lng_q == '0 && !rej_q), "block state not cleared after result")
  `IBRC_ASSERT(a_result_from_last, clk_i, rst_ni, $rose(out_valid_q) |-> $past(pop_last), "result raised without a last word")
  `IBRC_ASSERT(a_no_overwrite, clk_i, rst_ni, (out_valid_q && !out_ready_i) |-> !pop_last, "pending result overwritten")

endmodule

`default_nettype wire
